// ===== hdl/audio_ring_buffer_drop_oldest_assert.svh =====
// Assertion macros used by the checker file.
`ifndef AUDIO_RING_BUFFER_DROP_OLDEST_ASSERT_SVH
`define AUDIO_RING_BUFFER_DROP_OLDEST_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ARB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ARB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/arb_pkg.sv =====
package arb_pkg;

  localparam int FIFO_DEPTH = 8192;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;
  localparam int FRAC_W   = 15;
  localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;
  localparam int QUOT_W   = PROD_W - FRAC_W;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd32768;

  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam logic [PADDR_W-3:0] REG_VOLUME_GAIN = 1'd0;

  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_PULL  = 2'd1,
    FUNC_FLUSH = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCALE
  } arb_state_t;

  typedef struct packed {
    logic [1:0]                 func;
    logic signed [SAMPLE_W-1:0] sample_in;
  } arb_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       underrun;
  } arb_out_t;

endpackage

// ===== hdl/audio_ring_buffer_drop_oldest.sv =====
// Push, flush and no-op transactions leave the block ready and may follow back to back.
// A pull transaction is held through memory read, gain multiply and saturate.
// Its result passes the RAM read and product registers, then waits in the output register.
// The next transaction is accepted once the pull result has moved into the output register.
// Reset clears both pointers and sets the gain to unity; the sample memory is not cleared.
module audio_ring_buffer_drop_oldest (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  arb_pkg::arb_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output arb_pkg::arb_out_t             out_data,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [arb_pkg::PADDR_W-1:0]   cfg_paddr,
  input  logic [arb_pkg::PDATA_W-1:0]   cfg_pwdata,
  output logic [arb_pkg::PDATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  localparam int PW = arb_pkg::PTR_W;
  localparam logic [PW-1:0] PTR_LAST = PW'(arb_pkg::FIFO_DEPTH - 1);

  arb_pkg::arb_state_t state_r, state_nxt;

  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_inc, wr_inc;
  logic [arb_pkg::GAIN_W-1:0] gain_r;

  logic accept;
  logic empty;
  logic is_push, is_pull, is_flush;
  logic underrun_r;

  logic                               ram_wr_en;
  logic                               ram_rd_en;
  logic [arb_pkg::SAMPLE_W-1:0]       ram_rd_data;

  logic                               scale_load;
  logic signed [arb_pkg::SAMPLE_W-1:0] scaled;

  logic              out_load;
  logic              out_valid_r, out_valid_nxt;
  arb_pkg::arb_out_t out_data_r;

  logic cfg_wr;
  logic cfg_hit;

  // ---------------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------------
  assign accept   = in_valid && in_ready;
  assign is_push  = (in_data.func == arb_pkg::FUNC_PUSH);
  assign is_pull  = (in_data.func == arb_pkg::FUNC_PULL);
  assign is_flush = (in_data.func == arb_pkg::FUNC_FLUSH);
  assign empty    = (rd_ptr_r == wr_ptr_r);

  // Wrap at the last entry; the depth need not be a power of two.
  assign rd_inc = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
  assign wr_inc = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;

  // ---------------------------------------------------------------------------
  // Pointer update. Only one transaction is in flight, so a pull never reads an
  // entry that a write in the same cycle is still changing.
  // ---------------------------------------------------------------------------
  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    if (accept) begin
      if (is_push) begin
        wr_ptr_nxt = wr_inc;
        // Writer caught up with the reader: drop the oldest sample.
        if (wr_inc == rd_ptr_r) begin
          rd_ptr_nxt = rd_inc;
        end
      end else if (is_pull) begin
        if (!empty) begin
          rd_ptr_nxt = rd_inc;
        end
      end else if (is_flush) begin
        rd_ptr_nxt = '0;
        wr_ptr_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Sample memory: write on push, read on pull (the read data is registered and arrives later)
  // ---------------------------------------------------------------------------
  assign ram_wr_en = accept && is_push;
  assign ram_rd_en = accept && is_pull;

  arb_ram #(
    .WIDTH (arb_pkg::SAMPLE_W),
    .DEPTH (arb_pkg::FIFO_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (wr_ptr_r),
    .wr_data (in_data.sample_in),
    .rd_en   (ram_rd_en),
    .rd_addr (rd_ptr_r),
    .rd_data (ram_rd_data)
  );

  // Remember whether the pull found the FIFO empty.
  always_ff @(posedge clk) begin
    if (accept && is_pull) begin
      underrun_r <= empty;
    end
  end

  // ---------------------------------------------------------------------------
  // Gain multiply with floor rounding and saturation
  // ---------------------------------------------------------------------------
  arb_scale u_scale (
    .clk    (clk),
    .load   (scale_load),
    .sample (ram_rd_data),
    .gain   (gain_r),
    .result (scaled)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      arb_pkg::ST_IDLE: begin
        if (accept && is_pull) begin
          state_nxt = arb_pkg::ST_READ;
        end
      end
      arb_pkg::ST_READ: begin
        state_nxt = arb_pkg::ST_SCALE;
      end
      arb_pkg::ST_SCALE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = arb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = arb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    scale_load = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      arb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      arb_pkg::ST_READ: begin
        scale_load = 1'b1;
      end
      arb_pkg::ST_SCALE: begin
        // Load the output register once it is free or being emptied.
        out_load = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= arb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.sample_out <= underrun_r ? '0 : scaled;
      out_data_r.underrun   <= underrun_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr == {arb_pkg::REG_VOLUME_GAIN, 2'b00});
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= arb_pkg::GAIN_RESET;
    end else if (cfg_wr && cfg_hit) begin
      gain_r <= cfg_pwdata[arb_pkg::GAIN_W-1:0];
    end
  end

  assign cfg_prdata = cfg_hit ? {{(arb_pkg::PDATA_W-arb_pkg::GAIN_W){1'b0}}, gain_r} : '0;

endmodule

// ===== hdl/arb_ram.sv =====
module arb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/arb_scale.sv =====
module arb_scale (
  input  logic                                  clk,
  input  logic                                  load,
  input  logic signed [arb_pkg::SAMPLE_W-1:0]   sample,
  input  logic        [arb_pkg::GAIN_W-1:0]     gain,
  output logic signed [arb_pkg::SAMPLE_W-1:0]   result
);

  localparam int PW = arb_pkg::PROD_W;
  localparam int SW = arb_pkg::SAMPLE_W;
  localparam int QW = arb_pkg::QUOT_W;

  logic signed [PW-1:0] sample_ext;
  logic signed [PW-1:0] gain_ext;
  logic signed [PW-1:0] prod_nxt;
  logic signed [PW-1:0] prod_r;
  logic        [QW-1:0] quot;
  logic        [QW-SW:0] top_bits;

  // Sign-extend the sample, zero-extend the gain; the true product fits PW bits.
  assign sample_ext = {{(PW-SW){sample[SW-1]}}, sample};
  assign gain_ext   = {{(PW-arb_pkg::GAIN_W){1'b0}}, gain};
  assign prod_nxt   = sample_ext * gain_ext;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_nxt;
    end
  end

  // Dropping the fraction bits of a two's-complement value floors it.
  assign quot     = prod_r[PW-1:arb_pkg::FRAC_W];
  assign top_bits = quot[QW-1:SW-1];

  always_comb begin
    if ((&top_bits) || !(|top_bits)) begin
      result = quot[SW-1:0];
    end else if (quot[QW-1]) begin
      result = {1'b1, {(SW-1){1'b0}}};
    end else begin
      result = {1'b0, {(SW-1){1'b1}}};
    end
  end

endmodule

// ===== hdl/arb_checker.sv =====
`include "audio_ring_buffer_drop_oldest_assert.svh"

module arb_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input arb_pkg::arb_in_t            in_data,
  input logic                        out_valid,
  input logic                        out_ready,
  input arb_pkg::arb_out_t           out_data,
  input logic                        cfg_pready
);

  logic pull_acc;

  assign pull_acc = in_valid && in_ready && (in_data.func == arb_pkg::FUNC_PULL);

  `ARB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `ARB_ASSERT_NOW(a_underrun_zero, out_valid && out_data.underrun, out_data.sample_out == '0)
  `ARB_ASSERT_NEXT(a_pull_busy, pull_acc, !in_ready)
  `ARB_ASSERT_NEXT(a_pull_no_early_result, pull_acc && !out_valid, !out_valid)
  `ARB_ASSERT_NOW(a_pready_high, 1'b1, cfg_pready)

endmodule

bind audio_ring_buffer_drop_oldest arb_checker u_arb_checker (.*);
